// ===== rtl/pdfc_pkg.sv =====
package pdfc_pkg;

  localparam int COUNTER_BITS_DEF = 16;
  localparam int STAMP_W          = 16;
  localparam int FREQ_W           = 27;
  localparam int DUTY_W           = 7;
  localparam int STAT_W           = 2;
  localparam int DUTY_SCALE       = 100;
  localparam int DUTY_SCALE_W     = 7;

  localparam logic [FREQ_W-1:0] TICK_RATE_RESET = FREQ_W'(1000000);
  localparam logic [DUTY_W-1:0] DUTY_FULL       = DUTY_W'(DUTY_SCALE);

  localparam logic [STAT_W-1:0] STAT_MEAS    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_LEVEL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO_PD = 2'd2;

  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_POLL    = 1'b1;

  typedef enum logic [1:0] {
    PH_RISE1,
    PH_FALL,
    PH_RISE2,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EMIT_LVL,
    ST_EMIT_ZERO,
    ST_EMIT_MEAS
  } ctrl_state_t;

  typedef enum logic [1:0] {
    RES_LEVEL,
    RES_ZERO,
    RES_MEAS
  } res_sel_t;

  typedef struct packed {
    logic     cfg_we;
    logic     cap_we;
    logic     poll_take;
    logic     div_start;
    logic     out_load;
    res_sel_t res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic phase_done;
    logic period_zero;
    logic div_busy;
  } dp_stat_t;

endpackage

// ===== rtl/pdfc_in_if.sv =====
interface pdfc_in_if import pdfc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [STAMP_W-1:0] capture_time;
  logic               pin_level;

  modport source (output valid, output command, output capture_time, output pin_level,
                  input ready);
  modport sink   (input valid, input command, input capture_time, input pin_level,
                  output ready);
endinterface

// ===== rtl/pdfc_out_if.sv =====
interface pdfc_out_if import pdfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] frequency;
  logic [DUTY_W-1:0] duty_percent;
  logic [STAT_W-1:0] status;

  modport source (output valid, output frequency, output duty_percent, output status,
                  input ready);
  modport sink   (input valid, input frequency, input duty_percent, input status,
                  output ready);
endinterface

// ===== rtl/pdfc_cfg_if.sv =====
interface pdfc_cfg_if import pdfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] tick_rate;

  modport source (output valid, output tick_rate, input ready);
  modport sink   (input valid, input tick_rate, output ready);
endinterface

// ===== rtl/pdfc_div.sv =====
module pdfc_div import pdfc_pkg::*; #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   trial;

  // restoring division, one quotient bit per cycle, msb first
  assign trial = {rem_r, quo_r[NUM_W-1]};

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/pdfc_datapath.sv =====
module pdfc_datapath import pdfc_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  logic [FREQ_W-1:0]  cfg_tick_rate,
  input  logic [STAMP_W-1:0] in_capture_time,
  input  logic               in_pin_level,
  output dp_stat_t           stat,
  output logic [FREQ_W-1:0]  out_frequency,
  output logic [DUTY_W-1:0]  out_duty_percent,
  output logic [STAT_W-1:0]  out_status
);

  localparam int CB    = COUNTER_BITS;
  localparam int PER_W = CB + 1;
  localparam int HX_W  = CB + DUTY_SCALE_W;

  logic [FREQ_W-1:0] tick_rate_r, tick_rate_nxt;
  phase_t            phase_r, phase_nxt;
  logic [CB-1:0]     rise1_r, rise1_nxt;
  logic [CB-1:0]     fall_r, fall_nxt;
  logic [CB-1:0]     rise2_r, rise2_nxt;
  logic              level_r, level_nxt;
  logic [PER_W-1:0]  period_r, period_nxt;
  logic [HX_W-1:0]   high_x100_r, high_x100_nxt;
  logic [FREQ_W-1:0] freq_r, freq_nxt;
  logic [DUTY_W-1:0] duty_r, duty_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  logic [CB-1:0]     stamp;
  logic [CB-1:0]     high_t;
  logic [CB-1:0]     low_t;
  logic              busy_f, busy_d;
  logic [FREQ_W-1:0] quo_f;
  logic [HX_W-1:0]   quo_d;

  assign stamp  = CB'(in_capture_time);
  assign high_t = fall_r - rise1_r;
  assign low_t  = rise2_r - fall_r;

  always_comb begin
    tick_rate_nxt = tick_rate_r;
    phase_nxt     = phase_r;
    rise1_nxt     = rise1_r;
    fall_nxt      = fall_r;
    rise2_nxt     = rise2_r;
    level_nxt     = level_r;
    period_nxt    = period_r;
    high_x100_nxt = high_x100_r;
    if (cmd.cfg_we) begin
      tick_rate_nxt = cfg_tick_rate;
    end
    if (cmd.cap_we) begin
      case (phase_r)
        PH_RISE1: begin
          rise1_nxt = stamp;
          phase_nxt = PH_FALL;
        end
        PH_FALL: begin
          fall_nxt  = stamp;
          phase_nxt = PH_RISE2;
        end
        PH_RISE2: begin
          rise2_nxt = stamp;
          phase_nxt = PH_DONE;
        end
        default: ;
      endcase
    end
    if (cmd.poll_take) begin
      level_nxt     = in_pin_level;
      period_nxt    = {1'b0, high_t} + {1'b0, low_t};
      high_x100_nxt = HX_W'(high_t) * HX_W'(DUTY_SCALE);
      if (phase_r == PH_DONE) begin
        phase_nxt = PH_RISE1;
      end
    end
  end

  pdfc_div #(.NUM_W(FREQ_W), .DEN_W(PER_W)) u_div_freq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (tick_rate_r),
    .divisor  (period_r),
    .busy     (busy_f),
    .quotient (quo_f)
  );

  pdfc_div #(.NUM_W(HX_W), .DEN_W(PER_W)) u_div_duty (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (high_x100_r),
    .divisor  (period_r),
    .busy     (busy_d),
    .quotient (quo_d)
  );

  always_comb begin
    freq_nxt   = freq_r;
    duty_nxt   = duty_r;
    status_nxt = status_r;
    if (cmd.out_load) begin
      case (cmd.res_sel)
        RES_LEVEL: begin
          freq_nxt   = '0;
          duty_nxt   = level_r ? DUTY_FULL : '0;
          status_nxt = STAT_LEVEL;
        end
        RES_MEAS: begin
          freq_nxt   = quo_f;
          // high never exceeds period, so the quotient fits in the duty field
          duty_nxt   = quo_d[DUTY_W-1:0];
          status_nxt = STAT_MEAS;
        end
        default: begin
          freq_nxt   = '0;
          duty_nxt   = '0;
          status_nxt = STAT_ZERO_PD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rate_r <= TICK_RATE_RESET;
      phase_r     <= PH_RISE1;
      rise1_r     <= '0;
      fall_r      <= '0;
      rise2_r     <= '0;
    end else begin
      tick_rate_r <= tick_rate_nxt;
      phase_r     <= phase_nxt;
      rise1_r     <= rise1_nxt;
      fall_r      <= fall_nxt;
      rise2_r     <= rise2_nxt;
    end
    level_r     <= level_nxt;
    period_r    <= period_nxt;
    high_x100_r <= high_x100_nxt;
    freq_r      <= freq_nxt;
    duty_r      <= duty_nxt;
    status_r    <= status_nxt;
  end

  assign stat.phase_done  = (phase_r == PH_DONE);
  assign stat.period_zero = (period_r == '0);
  assign stat.div_busy    = busy_f | busy_d;

  assign out_frequency    = freq_r;
  assign out_duty_percent = duty_r;
  assign out_status       = status_r;

endmodule

// ===== rtl/pdfc_ctrl.sv =====
module pdfc_ctrl import pdfc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_command,
  input  logic     cfg_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     in_ready,
  output logic     cfg_ready,
  output logic     out_valid
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        in_xfer;
  logic        out_free;
  logic        emit;

  assign in_xfer  = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_command == CMD_POLL) begin
          state_nxt = stat.phase_done ? ST_CHECK : ST_EMIT_LVL;
        end
      end
      ST_CHECK: begin
        state_nxt = stat.period_zero ? ST_EMIT_ZERO : ST_DIV;
      end
      ST_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = ST_EMIT_MEAS;
        end
      end
      ST_EMIT_LVL, ST_EMIT_ZERO, ST_EMIT_MEAS: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    emit          = 1'b0;
    cmd.res_sel   = RES_LEVEL;
    cmd.div_start = 1'b0;
    case (state_r)
      ST_IDLE:      in_ready = 1'b1;
      ST_CHECK:     cmd.div_start = ~stat.period_zero;
      ST_EMIT_LVL:  emit = out_free;
      ST_EMIT_ZERO: begin
        emit        = out_free;
        cmd.res_sel = RES_ZERO;
      end
      ST_EMIT_MEAS: begin
        emit        = out_free;
        cmd.res_sel = RES_MEAS;
      end
      default: ;
    endcase
    cmd.cfg_we    = cfg_valid;
    cmd.cap_we    = in_xfer & (in_command == CMD_CAPTURE);
    cmd.poll_take = in_xfer & (in_command == CMD_POLL);
    cmd.out_load  = emit;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/pwm_duty_frequency_capture_core.sv =====
// pwm input capture: duty and frequency from rise, fall and second rise stamps
//
// in_bus  : items of command, capture_time, pin_level; transfer on valid & ready.
//           a capture gives no result; a poll gives one result.
// out_bus : frequency, duty_percent, status; held in an output register until taken.
// cfg_bus : tick_rate write, always ready; write only while no poll is in flight.
//
// a capture is accepted every cycle while no poll is in flight. a poll holds
// in_ready low until its result is loaded into the output register:
//   no complete measurement: poll, then emit step; zero period: poll, check, emit;
//   measured: poll, check, divide, emit, the divide step set by the two radix-2
//   dividers that run side by side, one quotient bit a cycle
// a result waiting on a stalled receiver does not block captures; the next poll
// waits in its emit step until the output register is free.
// reset clears the edge phase and stamps, sets tick_rate to 1000000 and empties
// the output register.
module pwm_duty_frequency_capture_core import pdfc_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  pdfc_in_if.sink    in_bus,
  pdfc_out_if.source out_bus,
  pdfc_cfg_if.sink   cfg_bus
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pdfc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_command (in_bus.command),
    .cfg_valid  (cfg_bus.valid),
    .out_ready  (out_bus.ready),
    .stat       (stat),
    .cmd        (cmd),
    .in_ready   (in_bus.ready),
    .cfg_ready  (cfg_bus.ready),
    .out_valid  (out_bus.valid)
  );

  pdfc_datapath #(.COUNTER_BITS(COUNTER_BITS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_tick_rate    (cfg_bus.tick_rate),
    .in_capture_time  (in_bus.capture_time),
    .in_pin_level     (in_bus.pin_level),
    .stat             (stat),
    .out_frequency    (out_bus.frequency),
    .out_duty_percent (out_bus.duty_percent),
    .out_status       (out_bus.status)
  );

endmodule

// ===== rtl/pdfc_checker.sv =====
module pdfc_checker import pdfc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [FREQ_W-1:0] out_frequency,
  input logic [DUTY_W-1:0] out_duty_percent,
  input logic [STAT_W-1:0] out_status
);

  // a result waiting on the receiver keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frequency)
      && $stable(out_duty_percent) && $stable(out_status))
    else $error("result changed while stalled");

  // measured duty never exceeds the full period
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_MEAS |-> out_duty_percent <= DUTY_FULL)
    else $error("measured duty above 100");

  // without a measurement there is no frequency
  a_no_meas_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_MEAS |-> out_frequency == '0)
    else $error("frequency given without a measurement");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind pwm_duty_frequency_capture_core pdfc_checker u_pdfc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_frequency    (out_bus.frequency),
  .out_duty_percent (out_bus.duty_percent),
  .out_status       (out_bus.status)
);
